// File: sv/cwbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwbs_pkg
// Shared types and codes for the coalescing write buffer scheduler.
// ----------------------------------------------------------------------------
package cwbs_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 7;
    localparam int DATA_W = 64;
    localparam int IN_TDATA_W = 120;
    localparam int OUT_TDATA_W = 120;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_ISSUE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        K_WACK    = 3'd0,
        K_RHIT    = 3'd1,
        K_RQUEUED = 3'd2,
        K_REJECT  = 3'd3,
        K_RISSUE  = 3'd4,
        K_WISSUE  = 3'd5,
        K_IDLE    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOOK = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    // where the result fields come from once memory data is back
    typedef enum logic [2:0] {
        SRC_REQ  = 3'd0,
        SRC_HIT  = 3'd1,
        SRC_RMEM = 3'd2,
        SRC_WMEM = 3'd3,
        SRC_ZERO = 3'd4
    } t_src;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_QUEUE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_QUEUE_LIMIT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] data;
    } t_wentry;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_rentry;

endpackage

// File: sv/coalescing_write_buffer_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_write_buffer_scheduler
// Write queue with coalescing and read forwarding, read queue, and a
// start/read/write issue scheduler; queue payloads live in synchronous rams.
// ----------------------------------------------------------------------------
// order: accept the input beat, tag lookup, ram data, then the result beat
// items are handled one at a time, with no overlap of tag lookup and ram read
// the next item is taken in the same cycle its predecessor's result is registered
// reset: i_rst_n low clears queue counts, heads, phase, burst count and the output
// reset loads threshold 32, read limit 32, write limit 64; rams are not cleared
module coalescing_write_buffer_scheduler #(
    parameter int WRITE_DEPTH = 64,
    parameter int READ_DEPTH  = 32,
    parameter int LINE_BYTES  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // addr[47:0], size[54:48], wdata[118:55], draining[119]
    input  logic [cwbs_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // mode[1:0]
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // out_addr[47:0], out_size[54:48], out_data[118:55], zero[119]
    output logic [cwbs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // kind[2:0]
    output logic [2:0]                          o_m_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cwbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cwbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cwbs_pkg::*;

    localparam int WAW = $clog2(WRITE_DEPTH);
    localparam int RAW = $clog2(READ_DEPTH);
    localparam int WCW = $clog2(WRITE_DEPTH + 1);
    localparam int RCW = $clog2(READ_DEPTH + 1);
    localparam int CMPW = 10;

    // config
    logic [6:0] r_thr;
    logic [5:0] r_rlim;
    logic [6:0] r_wlim;

    // control state
    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [6:0]     r_burst, n_burst;
    logic [WCW-1:0] r_wcnt, n_wcnt;
    logic [WAW-1:0] r_whead, n_whead;
    logic [RCW-1:0] r_rcnt, n_rcnt;
    logic [RAW-1:0] r_rhead, n_rhead;

    // captured item
    t_mode             r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [DATA_W-1:0] r_wdata;
    logic              r_drain;

    // pending result
    t_kind r_kind, n_kind;
    t_src  r_src, n_src;

    // output register
    logic              r_ovalid;
    t_kind             r_okind;
    logic [ADDR_W-1:0] r_oaddr;
    logic [SIZE_W-1:0] r_osize;
    logic [DATA_W-1:0] r_odata;

    // rams and tags
    t_wentry           wmem [WRITE_DEPTH];
    t_rentry           rmem [READ_DEPTH];
    t_wentry           r_wrd;
    t_rentry           r_rrd;
    logic [ADDR_W-1:0] r_tag_addr [WRITE_DEPTH];
    logic [SIZE_W-1:0] r_tag_size [WRITE_DEPTH];

    logic out_free, s_acc, look;
    assign out_free = !r_ovalid || i_m_tready;
    assign look     = (r_state == ST_LOOK);

    function automatic logic [WAW-1:0] first_set(input logic [WRITE_DEPTH-1:0] v);
        logic [WAW-1:0] idx;
        idx = '0;
        for (int i = WRITE_DEPTH - 1; i >= 0; i--) begin
            if (v[i]) idx = WAW'(i);
        end
        return idx;
    endfunction

    // ---------------- fsm ----------------
    always_comb begin
        o_s_tready = (r_state == ST_IDLE) || ((r_state == ST_OUT) && out_free);
    end
    assign s_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = s_acc ? ST_LOOK : ST_IDLE;
            ST_LOOK: n_state = ST_OUT;
            ST_OUT: begin
                if (!out_free) n_state = ST_OUT;
                else n_state = s_acc ? ST_LOOK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- tag lookup ----------------
    logic [WRITE_DEPTH-1:0] vld, amatch, cmatch, ge_head;
    always_comb begin
        for (int i = 0; i < WRITE_DEPTH; i++) begin
            logic [CMPW-1:0] rel;
            rel = CMPW'(i) - CMPW'(r_whead)
                + ((WAW'(i) < r_whead) ? CMPW'(WRITE_DEPTH) : CMPW'(0));
            vld[i]     = rel < CMPW'(r_wcnt);
            ge_head[i] = !(WAW'(i) < r_whead);
            amatch[i]  = vld[i] && (r_tag_addr[i] == r_addr);
            cmatch[i]  = amatch[i] && (r_tag_size[i] == r_size);
        end
    end

    logic           line_read, rhit, coal;
    logic [WAW-1:0] hit_idx, coal_idx, wtail;
    logic [RAW-1:0] rtail;
    logic [CMPW-1:0] wsum, rsum;
    assign line_read = (CMPW'(r_size) == CMPW'(LINE_BYTES));
    assign rhit      = line_read && (|amatch);
    // oldest match: first at or after the head, else first from slot zero
    assign hit_idx   = (|(amatch & ge_head)) ? first_set(amatch & ge_head)
                                             : first_set(amatch);
    assign coal      = |cmatch;
    assign coal_idx  = first_set(cmatch);
    assign wsum      = CMPW'(r_whead) + CMPW'(r_wcnt);
    assign wtail     = (wsum >= CMPW'(WRITE_DEPTH)) ? WAW'(wsum - CMPW'(WRITE_DEPTH))
                                                    : WAW'(wsum);
    assign rsum      = CMPW'(r_rhead) + CMPW'(r_rcnt);
    assign rtail     = (rsum >= CMPW'(READ_DEPTH)) ? RAW'(rsum - CMPW'(READ_DEPTH))
                                                   : RAW'(rsum);

    logic [CMPW-1:0] wlim, rlim;
    assign wlim = (CMPW'(r_wlim) < CMPW'(WRITE_DEPTH)) ? CMPW'(r_wlim)
                                                       : CMPW'(WRITE_DEPTH);
    assign rlim = (CMPW'(r_rlim) < CMPW'(READ_DEPTH)) ? CMPW'(r_rlim)
                                                      : CMPW'(READ_DEPTH);

    logic           wq_we, rq_we, tag_we;
    logic [WAW-1:0] wq_widx, wq_ridx;

    // ---------------- request decode and scheduler ----------------
    always_comb begin
        logic   force_w;
        t_phase ph;
        logic [6:0] b1;
        n_phase = r_phase;
        n_burst = r_burst;
        n_wcnt  = r_wcnt;
        n_whead = r_whead;
        n_rcnt  = r_rcnt;
        n_rhead = r_rhead;
        n_kind  = K_IDLE;
        n_src   = SRC_ZERO;
        wq_we   = 1'b0;
        tag_we  = 1'b0;
        rq_we   = 1'b0;
        wq_widx = coal_idx;
        wq_ridx = (r_mode == MODE_READ) ? hit_idx : r_whead;
        force_w = r_drain && (r_wcnt != '0);
        ph      = r_phase;
        b1      = r_burst + 7'd1;
        case (r_mode)
            MODE_READ: begin
                n_src = SRC_REQ;
                if (rhit) begin
                    n_kind = K_RHIT;
                    n_src  = SRC_HIT;
                end else if (CMPW'(r_rcnt) >= rlim) begin
                    n_kind = K_REJECT;
                end else begin
                    n_kind = K_RQUEUED;
                    rq_we  = 1'b1;
                    n_rcnt = r_rcnt + RCW'(1);
                end
            end
            MODE_WRITE: begin
                n_src = SRC_REQ;
                if (CMPW'(r_wcnt) >= wlim) begin
                    n_kind = K_REJECT;
                end else begin
                    n_kind = K_WACK;
                    wq_we  = 1'b1;
                    if (!coal) begin
                        wq_widx = wtail;
                        tag_we  = 1'b1;
                        n_wcnt  = r_wcnt + WCW'(1);
                    end
                end
            end
            MODE_ISSUE: begin
                if (ph != PH_READ && ph != PH_WRITE) begin
                    if (force_w || (CMPW'(r_wcnt) >= CMPW'(r_thr))) ph = PH_WRITE;
                    else if (r_rcnt != '0) ph = PH_READ;
                    else ph = PH_START;
                end
                case (ph)
                    PH_READ: begin
                        if (r_rcnt == '0) begin
                            n_phase = PH_START;
                        end else begin
                            n_kind  = K_RISSUE;
                            n_src   = SRC_RMEM;
                            n_rhead = (r_rhead == RAW'(READ_DEPTH - 1)) ? '0
                                                                        : r_rhead + RAW'(1);
                            n_rcnt  = r_rcnt - RCW'(1);
                            if (force_w || (CMPW'(r_wcnt) > CMPW'(r_thr))) n_phase = PH_WRITE;
                            else if (r_rcnt == RCW'(1)) n_phase = PH_START;
                            else n_phase = PH_READ;
                        end
                    end
                    PH_WRITE: begin
                        if (r_wcnt == '0) begin
                            n_phase = PH_START;
                            n_burst = '0;
                        end else begin
                            n_kind  = K_WISSUE;
                            n_src   = SRC_WMEM;
                            n_whead = (r_whead == WAW'(WRITE_DEPTH - 1)) ? '0
                                                                         : r_whead + WAW'(1);
                            n_wcnt  = r_wcnt - WCW'(1);
                            if ((b1 >= r_thr) || (r_wcnt == WCW'(1))) begin
                                n_phase = PH_START;
                                n_burst = '0;
                            end else begin
                                n_phase = PH_WRITE;
                                n_burst = b1;
                            end
                        end
                    end
                    default: n_phase = PH_START;
                endcase
            end
            default: begin
                n_kind = K_IDLE;
                n_src  = SRC_ZERO;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_START;
            r_burst <= '0;
            r_wcnt  <= '0;
            r_whead <= '0;
            r_rcnt  <= '0;
            r_rhead <= '0;
            r_thr   <= 7'd32;
            r_rlim  <= 6'd32;
            r_wlim  <= 7'd64;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (look) begin
                r_phase <= n_phase;
                r_burst <= n_burst;
                r_wcnt  <= n_wcnt;
                r_whead <= n_whead;
                r_rcnt  <= n_rcnt;
                r_rhead <= n_rhead;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WRITE_THRESHOLD:   r_thr  <= i_cfg_data;
                    CFG_READ_QUEUE_LIMIT:  r_rlim <= i_cfg_data[5:0];
                    CFG_WRITE_QUEUE_LIMIT: r_wlim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && out_free) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode  <= t_mode'(i_s_tuser);
            r_addr  <= i_s_tdata[47:0];
            r_size  <= i_s_tdata[54:48];
            r_wdata <= i_s_tdata[118:55];
            r_drain <= i_s_tdata[119];
        end
        if (look) begin
            r_kind <= n_kind;
            r_src  <= n_src;
        end
        if (r_state == ST_OUT && out_free) begin
            r_okind <= r_kind;
            case (r_src)
                SRC_REQ: begin
                    r_oaddr <= r_addr;
                    r_osize <= r_size;
                    r_odata <= '0;
                end
                SRC_HIT: begin
                    r_oaddr <= r_addr;
                    r_osize <= r_size;
                    r_odata <= r_wrd.data;
                end
                SRC_RMEM: begin
                    r_oaddr <= r_rrd.addr;
                    r_osize <= r_rrd.size;
                    r_odata <= '0;
                end
                SRC_WMEM: begin
                    r_oaddr <= r_wrd.addr;
                    r_osize <= r_wrd.size;
                    r_odata <= r_wrd.data;
                end
                default: begin
                    r_oaddr <= '0;
                    r_osize <= '0;
                    r_odata <= '0;
                end
            endcase
        end
    end

    // ---------------- rams ----------------
    // read data is held while the result waits for the output register
    always_ff @(posedge i_clk) begin
        if (look && wq_we) wmem[wq_widx] <= '{addr: r_addr, size: r_size, data: r_wdata};
        if (look) r_wrd <= wmem[wq_ridx];
    end

    always_ff @(posedge i_clk) begin
        if (look && rq_we) rmem[rtail] <= '{addr: r_addr, size: r_size};
        if (look) r_rrd <= rmem[r_rhead];
    end

    always_ff @(posedge i_clk) begin
        if (look && tag_we) begin
            r_tag_addr[wtail] <= r_addr;
            r_tag_size[wtail] <= r_size;
        end
    end

    assign o_m_tvalid  = r_ovalid;
    assign o_m_tuser   = r_okind;
    assign o_m_tdata   = {1'b0, r_odata, r_osize, r_oaddr};
    assign o_cfg_ready = 1'b1;

endmodule

// File: sv/cwbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwbs_checker
// Port-level checks for the coalescing write buffer scheduler.
// ----------------------------------------------------------------------------
module cwbs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [cwbs_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [2:0]                       o_m_tuser
);
    import cwbs_pkg::*;

    // a stalled result beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // nothing is presented right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an accepted beat goes through the tag lookup before the next one is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken during lookup");

    // idle results carry all-zero fields
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == K_IDLE) |-> (o_m_tdata == '0))
        else $error("idle result with nonzero fields");

endmodule

bind coalescing_write_buffer_scheduler cwbs_checker u_cwbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
